// ===== design/ebalu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ebalu_pkg: shared types and constants for the eight-bit ALU pipeline
// Operation codes, flag bit positions and the stage-to-stage payload structs.
// ----------------------------------------------------------------------------
package ebalu_pkg;

    typedef enum logic [3:0] {
        CMD_INC8  = 4'd0,
        CMD_DEC8  = 4'd1,
        CMD_INC16 = 4'd2,
        CMD_DEC16 = 4'd3,
        CMD_ADD16 = 4'd4,
        CMD_ADD   = 4'd5,
        CMD_SUB   = 4'd6,
        CMD_ADC   = 4'd7,
        CMD_SBC   = 4'd8,
        CMD_SCF   = 4'd9,
        CMD_CCF   = 4'd10,
        CMD_CPL   = 4'd11,
        CMD_DAA   = 4'd12
    } cmd_t;

    // flag byte bit positions
    localparam int unsigned FLAG_S  = 7;
    localparam int unsigned FLAG_Z  = 6;
    localparam int unsigned FLAG_H  = 4;
    localparam int unsigned FLAG_PV = 2;
    localparam int unsigned FLAG_N  = 1;
    localparam int unsigned FLAG_C  = 0;

    localparam logic [3:0] CYC_SHORT = 4'd4;
    localparam logic [3:0] CYC_WORD  = 4'd6;
    localparam logic [3:0] CYC_LONG  = 4'd11;

    // decoded word, leaving the decode stage
    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  acc;
        logic [7:0]  flags;
        logic [7:0]  operand;
        logic [7:0]  byte_b;     // +1 or -1 for inc8/dec8
        logic [7:0]  alu_b;      // operand, inverted for subtraction
        logic        alu_cin;
        logic        alu_sub;
        logic [15:0] wide_dest;
        logic [15:0] wide_b;     // +1, -1 or wide source
        logic        from_memory;
        logic [7:0]  daa_corr;
        logic        daa_hi;
    } dec_t;

    // adder results, leaving the execute stage
    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  acc;
        logic [7:0]  flags;
        logic        from_memory;
        logic [7:0]  alu_r;
        logic        alu_c;
        logic        alu_h;
        logic        alu_pv;
        logic [7:0]  byte_r;
        logic [15:0] word_r;
        logic        word_c;
        logic        word_h;
        logic [7:0]  daa_r;
        logic        daa_hi;
    } exe_t;

endpackage
`default_nettype wire

// ===== design/ebalu_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ebalu_decode: first pipeline stage
// Capture the input word and prepare adder operands, carry-in and DAA
// correction for the execute stage.
// ----------------------------------------------------------------------------
module ebalu_decode (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire logic [3:0]     cmd,
    input  wire logic [7:0]     acc_in,
    input  wire logic [7:0]     flags_in,
    input  wire logic [7:0]     operand,
    input  wire logic [15:0]    wide_dest,
    input  wire logic [15:0]    wide_src,
    input  wire logic           from_memory,
    output logic                dec_valid,
    output ebalu_pkg::dec_t     dec
);
    import ebalu_pkg::*;

    dec_t dec_next;
    dec_t dec_reg;
    logic valid_reg;
    logic corr_lo;

    always_comb
    begin
        dec_next             = '0;
        dec_next.cmd         = cmd_t'(cmd);
        dec_next.acc         = acc_in;
        dec_next.flags       = flags_in;
        dec_next.operand     = operand;
        dec_next.wide_dest   = wide_dest;
        dec_next.from_memory = from_memory;
        dec_next.byte_b      = (cmd_t'(cmd) == CMD_DEC8) ? 8'hFF : 8'h01;

        unique case (cmd_t'(cmd))
            CMD_ADC:
            begin
                dec_next.alu_b   = operand;
                dec_next.alu_cin = flags_in[FLAG_C];
            end
            CMD_SUB:
            begin
                dec_next.alu_b   = ~operand;
                dec_next.alu_cin = 1'b1;
                dec_next.alu_sub = 1'b1;
            end
            CMD_SBC:
            begin
                dec_next.alu_b   = ~operand;
                dec_next.alu_cin = ~flags_in[FLAG_C];
                dec_next.alu_sub = 1'b1;
            end
            default:
            begin
                dec_next.alu_b   = operand;
            end
        endcase

        unique case (cmd_t'(cmd))
            CMD_INC16: dec_next.wide_b = 16'h0001;
            CMD_DEC16: dec_next.wide_b = 16'hFFFF;
            default:   dec_next.wide_b = wide_src;
        endcase

        // 0x06 for the low digit, 0x60 for the high digit
        corr_lo = flags_in[FLAG_H] || (acc_in[3:0] > 4'd9);
        dec_next.daa_hi   = flags_in[FLAG_C] || (acc_in > 8'h99);
        dec_next.daa_corr = {1'b0, dec_next.daa_hi, dec_next.daa_hi, 1'b0,
                             1'b0, corr_lo, corr_lo, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dec_reg <= dec_next;
        end
    end

    assign dec_valid = valid_reg;
    assign dec       = dec_reg;

endmodule
`default_nettype wire

// ===== design/ebalu_exec.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ebalu_exec: second pipeline stage
// Run the 8-bit, 16-bit, inc/dec and DAA adders and register raw flag terms.
// ----------------------------------------------------------------------------
module ebalu_exec (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           dec_valid,
    input  wire ebalu_pkg::dec_t dec,
    output logic                exe_valid,
    output ebalu_pkg::exe_t     exe
);
    import ebalu_pkg::*;

    exe_t        exe_next;
    exe_t        exe_reg;
    logic        valid_reg;
    logic [8:0]  alu_sum;
    logic [4:0]  nib_sum;
    logic [16:0] word_sum;
    logic [12:0] low12_sum;

    always_comb
    begin
        alu_sum   = {1'b0, dec.acc} + {1'b0, dec.alu_b} + {8'd0, dec.alu_cin};
        nib_sum   = {1'b0, dec.acc[3:0]} + {1'b0, dec.alu_b[3:0]} + {4'd0, dec.alu_cin};
        word_sum  = {1'b0, dec.wide_dest} + {1'b0, dec.wide_b};
        low12_sum = {1'b0, dec.wide_dest[11:0]} + {1'b0, dec.wide_b[11:0]};

        exe_next             = '0;
        exe_next.cmd         = dec.cmd;
        exe_next.acc         = dec.acc;
        exe_next.flags       = dec.flags;
        exe_next.from_memory = dec.from_memory;
        exe_next.alu_r       = alu_sum[7:0];
        // a carry out of the inverted-operand add means no borrow
        exe_next.alu_c       = alu_sum[8] ^ dec.alu_sub;
        exe_next.alu_h       = nib_sum[4] ^ dec.alu_sub;
        exe_next.alu_pv      = (dec.acc[7] ^ alu_sum[7]) & (dec.alu_b[7] ^ alu_sum[7]);
        exe_next.byte_r      = dec.operand + dec.byte_b;
        exe_next.word_r      = word_sum[15:0];
        exe_next.word_c      = word_sum[16];
        exe_next.word_h      = low12_sum[12];
        exe_next.daa_r       = dec.flags[FLAG_N] ? (dec.acc - dec.daa_corr)
                                                 : (dec.acc + dec.daa_corr);
        exe_next.daa_hi      = dec.daa_hi;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= dec_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dec_valid)
        begin
            exe_reg <= exe_next;
        end
    end

    assign exe_valid = valid_reg;
    assign exe       = exe_reg;

endmodule
`default_nettype wire

// ===== design/ebalu_flags.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ebalu_flags: third pipeline stage
// Select results per operation, assemble the flag byte and register outputs.
// ----------------------------------------------------------------------------
module ebalu_flags (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           exe_valid,
    input  wire ebalu_pkg::exe_t exe,
    output logic                done,
    output logic [7:0]          acc_out,
    output logic [7:0]          byte_result,
    output logic [15:0]         word_result,
    output logic [7:0]          flags_out,
    output logic [3:0]          cycle_count
);
    import ebalu_pkg::*;

    logic        done_reg;
    logic [7:0]  acc_next,   acc_reg;
    logic [7:0]  byte_next,  byte_reg;
    logic [15:0] word_next,  word_reg;
    logic [7:0]  flags_next, flags_reg;
    logic [3:0]  cyc_next,   cyc_reg;

    always_comb
    begin
        acc_next   = exe.acc;
        byte_next  = 8'd0;
        word_next  = 16'd0;
        flags_next = exe.flags;
        cyc_next   = CYC_SHORT;

        unique case (exe.cmd)
            CMD_INC8, CMD_DEC8:
            begin
                byte_next             = exe.byte_r;
                flags_next[FLAG_S]    = exe.byte_r[7];
                flags_next[FLAG_Z]    = (exe.byte_r == 8'h00);
                if (exe.cmd == CMD_INC8)
                begin
                    flags_next[FLAG_H]  = (exe.byte_r[3:0] == 4'h0);
                    flags_next[FLAG_PV] = (exe.byte_r == 8'h80);
                    flags_next[FLAG_N]  = 1'b0;
                end
                else
                begin
                    flags_next[FLAG_H]  = (exe.byte_r[3:0] == 4'hF);
                    flags_next[FLAG_PV] = (exe.byte_r == 8'h7F);
                    flags_next[FLAG_N]  = 1'b1;
                end
                cyc_next = exe.from_memory ? CYC_LONG : CYC_SHORT;
            end
            CMD_INC16, CMD_DEC16:
            begin
                word_next = exe.word_r;
                cyc_next  = CYC_WORD;
            end
            CMD_ADD16:
            begin
                word_next          = exe.word_r;
                flags_next[FLAG_C] = exe.word_c;
                flags_next[FLAG_H] = exe.word_h;
                flags_next[FLAG_N] = 1'b0;
                cyc_next           = CYC_LONG;
            end
            CMD_ADD, CMD_ADC, CMD_SUB, CMD_SBC:
            begin
                acc_next            = exe.alu_r;
                flags_next[FLAG_S]  = exe.alu_r[7];
                flags_next[FLAG_Z]  = (exe.alu_r == 8'h00);
                flags_next[FLAG_H]  = exe.alu_h;
                flags_next[FLAG_PV] = exe.alu_pv;
                flags_next[FLAG_C]  = exe.alu_c;
                flags_next[FLAG_N]  = (exe.cmd == CMD_SUB) || (exe.cmd == CMD_SBC);
            end
            CMD_SCF:
            begin
                flags_next[FLAG_C] = 1'b1;
                flags_next[FLAG_H] = 1'b0;
                flags_next[FLAG_N] = 1'b0;
            end
            CMD_CCF:
            begin
                flags_next[FLAG_H] = exe.flags[FLAG_C];
                flags_next[FLAG_C] = ~exe.flags[FLAG_C];
                flags_next[FLAG_N] = 1'b0;
            end
            CMD_CPL:
            begin
                acc_next           = ~exe.acc;
                flags_next[FLAG_H] = 1'b1;
                flags_next[FLAG_N] = 1'b1;
            end
            CMD_DAA:
            begin
                acc_next           = exe.daa_r;
                flags_next[FLAG_C] = exe.flags[FLAG_C] | exe.daa_hi;
                flags_next[FLAG_S] = exe.daa_r[7];
                flags_next[FLAG_Z] = (exe.daa_r == 8'h00);
            end
            default:
            begin
                // unused codes pass accumulator and flags through
                acc_next = exe.acc;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= exe_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exe_valid)
        begin
            acc_reg   <= acc_next;
            byte_reg  <= byte_next;
            word_reg  <= word_next;
            flags_reg <= flags_next;
            cyc_reg   <= cyc_next;
        end
    end

    assign done        = done_reg;
    assign acc_out     = acc_reg;
    assign byte_result = byte_reg;
    assign word_result = word_reg;
    assign flags_out   = flags_reg;
    assign cycle_count = cyc_reg;

endmodule
`default_nettype wire

// ===== design/eight_bit_cpu_alu_with_flags.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eight_bit_cpu_alu_with_flags: pipelined eight-bit CPU ALU with flag byte
// Executes inc/dec on bytes and words, 16-bit add, add/adc/sub/sbc, scf, ccf,
// cpl and daa, returning new accumulator, byte/word results, flags and the
// instruction T-state count.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  --------  -------------------  --------------------------------------------
//  command   start / busy         cmd acc_in flags_in operand wide_dest
//                                 wide_src from_memory
//  result    done (one cycle)     acc_out byte_result word_result flags_out
//                                 cycle_count
//
//  A word is taken on every edge where start is high and busy is low; busy
//  stays low, so one word can enter every cycle.
//  Each result passes the decode, execute (adders) and flag assembly
//  stages in that order; flag assembly drives the output register.
//  The receiver cannot stall; each result shows for one cycle with done.
//  Reset clears the valid bits of all three stages; no word in flight
//  survives reset.
//
module eight_bit_cpu_alu_with_flags (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [3:0]  cmd,
    input  wire logic [7:0]  acc_in,
    input  wire logic [7:0]  flags_in,
    input  wire logic [7:0]  operand,
    input  wire logic [15:0] wide_dest,
    input  wire logic [15:0] wide_src,
    input  wire logic        from_memory,
    output logic             done,
    output logic [7:0]       acc_out,
    output logic [7:0]       byte_result,
    output logic [15:0]      word_result,
    output logic [7:0]       flags_out,
    output logic [3:0]       cycle_count
);
    import ebalu_pkg::*;

    logic dec_valid;
    dec_t dec;
    logic exe_valid;
    exe_t exe;
    logic accept;

    // every stage advances every cycle, so there is never back-pressure
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // stage 1: capture command, pick adder operands and DAA correction
    ebalu_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .cmd         (cmd),
        .acc_in      (acc_in),
        .flags_in    (flags_in),
        .operand     (operand),
        .wide_dest   (wide_dest),
        .wide_src    (wide_src),
        .from_memory (from_memory),
        .dec_valid   (dec_valid),
        .dec         (dec)
    );

    // stage 2: run all adders in parallel
    ebalu_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec_valid (dec_valid),
        .dec       (dec),
        .exe_valid (exe_valid),
        .exe       (exe)
    );

    // stage 3: select per operation and drive the result register
    ebalu_flags u_flags (
        .clk         (clk),
        .rst_n       (rst_n),
        .exe_valid   (exe_valid),
        .exe         (exe),
        .done        (done),
        .acc_out     (acc_out),
        .byte_result (byte_result),
        .word_result (word_result),
        .flags_out   (flags_out),
        .cycle_count (cycle_count)
    );

    // every accepted command produces a result on done
    a_accept_to_done : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("accepted command produced no result");

    // no result without an earlier accepted command
    a_done_has_cmd : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 3))
        else $error("result without a matching command");

    // only three T-state counts exist
    a_cycle_legal : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cycle_count == CYC_SHORT || cycle_count == CYC_WORD ||
                  cycle_count == CYC_LONG))
        else $error("illegal cycle count");

    // an operation writes a byte result or a word result, never both
    a_one_result : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (byte_result == 8'd0 || word_result == 16'd0))
        else $error("byte and word results both written");

endmodule
`default_nettype wire
